// ===== design/sc2d_pkg.sv =====
// Shared constants, codes and types of the strided 2D convolution block.
// No dependencies; sc2d_cell and strided_conv2d_top refer to it by scoped names.
`default_nettype none
package sc2d_pkg;

	// default sizes handed to the top level parameters
	localparam int MAX_IMAGE_DEF  = 64;
	localparam int MAX_KERNEL_DEF = 8;
	localparam int VALUE_BITS_DEF = 16;

	// configuration register widths and indexes
	localparam int IMAGE_W     = 7;
	localparam int KERNEL_W    = 4;
	localparam int STRIDE_W    = 7;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KERNEL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE = 2'd2;

	localparam logic [IMAGE_W-1:0]  IMAGE_RST  = 7'd64;
	localparam logic [KERNEL_W-1:0] KERNEL_RST = 4'd3;
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 7'd1;

	// item opcodes
	localparam logic OP_WEIGHT = 1'b0;
	localparam logic OP_PIXEL  = 1'b1;

	// result status codes
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_KERNEL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_STRIDE = 2'd2;

	localparam int POS_OUT_W = 6;

	// control flags travelling with a column token along the cell chain
	typedef struct packed {
		logic valid;
		logic last;
	} flag_t;

endpackage
`default_nettype wire

// ===== design/sc2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sc2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/sc2d_div.sv =====
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on nothing but its parameters.
`default_nettype none
module sc2d_div #(
	parameter int NW = 7,
	parameter int DW = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] n,
	input  wire logic [DW-1:0] d,
	output logic               done,
	output logic      [NW-1:0] q,
	output logic      [DW-1:0] rem
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem, q[NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// shift the dividend out of q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			q   <= n;
			rem <= '0;
			d_q <= d;
		end else if (busy_q) begin
			q   <= {q[NW-2:0], fits};
			rem <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== design/sc2d_cell.sv =====
// One cell of the convolution chain: owns copies of the line and weight stores,
// multiplies one window row's pixel by its weight and adds it to the neighbor's sum.
// Depends on sc2d_pkg and sc2d_ram.
`default_nettype none
module sc2d_cell #(
	parameter int IDX        = 0,
	parameter int MAX_IMAGE  = sc2d_pkg::MAX_IMAGE_DEF,
	parameter int MAX_KERNEL = sc2d_pkg::MAX_KERNEL_DEF,
	parameter int VALUE_BITS = sc2d_pkg::VALUE_BITS_DEF,
	localparam int PW  = $clog2(MAX_IMAGE),
	localparam int KW  = $clog2(MAX_KERNEL + 1),
	localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
	localparam int WD  = MAX_KERNEL * MAX_KERNEL,
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1,
	localparam int LD  = MAX_KERNEL * MAX_IMAGE,
	localparam int LAW = $clog2(LD),
	localparam int SW  = 2 * VALUE_BITS + $clog2(WD)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [KW-1:0]          k,
	input  wire logic                   lw_en,
	input  wire logic [LAW-1:0]         lw_addr,
	input  wire logic [VALUE_BITS-1:0]  lw_data,
	input  wire logic                   ww_en,
	input  wire logic [WAW-1:0]         ww_addr,
	input  wire logic [VALUE_BITS-1:0]  ww_data,
	input  wire sc2d_pkg::flag_t        tok_in,
	input  wire logic [SLW-1:0]         slot_in,
	input  wire logic [PW-1:0]          col_in,
	input  wire logic [WAW-1:0]         wa_in,
	output sc2d_pkg::flag_t             tok_out,
	output logic      [SLW-1:0]         slot_out,
	output logic      [PW-1:0]          col_out,
	output logic      [WAW-1:0]         wa_out,
	input  wire logic [SW-1:0]          psum_in,
	output logic      [SW-1:0]          psum_out,
	output sc2d_pkg::flag_t             sflag_out
);
	logic [LAW-1:0]                raddr;
	logic [VALUE_BITS-1:0]         pix_s1;
	logic [VALUE_BITS-1:0]         wgt_s1;
	logic                          act_s1;
	sc2d_pkg::flag_t               flag_s1;
	sc2d_pkg::flag_t               flag_s2;
	logic signed [2*VALUE_BITS-1:0] prod_s2;
	logic [SLW:0]                  slot_inc;

	assign raddr    = LAW'(slot_in) * LAW'(MAX_IMAGE) + LAW'(col_in);
	assign slot_inc = {1'b0, slot_in} + 1'b1;

	sc2d_ram #(.WIDTH(VALUE_BITS), .DEPTH(LD)) u_line (
		.clk(clk), .we(lw_en), .waddr(lw_addr), .wdata(lw_data),
		.raddr(raddr), .rdata(pix_s1)
	);

	sc2d_ram #(.WIDTH(VALUE_BITS), .DEPTH(WD)) u_wgt (
		.clk(clk), .we(ww_en), .waddr(ww_addr), .wdata(ww_data),
		.raddr(wa_in), .rdata(wgt_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out   <= '0;
			flag_s1   <= '0;
			flag_s2   <= '0;
			sflag_out <= '0;
		end else begin
			tok_out   <= tok_in;
			flag_s1   <= tok_in;
			flag_s2   <= flag_s1;
			sflag_out <= flag_s2;
		end
	end

	// hand the token on: next window row, next line slot, next weight row
	always_ff @(posedge clk) begin
		slot_out <= (32'(slot_inc) >= 32'(k)) ? '0 : slot_inc[SLW-1:0];
		col_out  <= col_in;
		wa_out   <= wa_in + WAW'(k);
		act_s1   <= tok_in.valid && (32'(IDX) < 32'(k));
		if (act_s1) begin
			prod_s2 <= $signed(pix_s1) * $signed(wgt_s1);
		end else begin
			prod_s2 <= '0;
		end
		psum_out <= psum_in + SW'(prod_s2);
	end
endmodule
`default_nettype wire

// ===== design/strided_conv2d_top.sv =====
// Strided valid 2D convolution: top level with control sequencer and cell chain.
// Weight items are taken in the idle state. A pixel that closes a window goes through four
// serial divider passes and then sends k column tokens through the MAX_KERNEL-cell chain.
// Other pixels skip the top and left divisions and the chain.
// One item at a time; emit waits while the output register still holds an unread result.
// Reset (arst_n low): registers to 64/3/1, positions, phases and weight index to zero.
`default_nettype none
module strided_conv2d_top #(
	parameter int MAX_IMAGE  = sc2d_pkg::MAX_IMAGE_DEF,
	parameter int MAX_KERNEL = sc2d_pkg::MAX_KERNEL_DEF,
	parameter int VALUE_BITS = sc2d_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [sc2d_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [sc2d_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  opcode,
	input  wire logic [VALUE_BITS-1:0]                 value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [2*VALUE_BITS+$clog2(MAX_KERNEL*MAX_KERNEL)-1:0] sum,
	output logic [sc2d_pkg::POS_OUT_W-1:0]             out_row,
	output logic [sc2d_pkg::POS_OUT_W-1:0]             out_col,
	output logic                                       last,
	output logic [sc2d_pkg::STATUS_W-1:0]              status
);
	localparam int PW  = $clog2(MAX_IMAGE);
	localparam int MW  = $clog2(MAX_IMAGE + 1);
	localparam int KW  = $clog2(MAX_KERNEL + 1);
	localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int WD  = MAX_KERNEL * MAX_KERNEL;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int LAW = $clog2(MAX_KERNEL * MAX_IMAGE);
	localparam int SW  = 2 * VALUE_BITS + $clog2(WD);
	localparam int DW  = sc2d_pkg::STRIDE_W;

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MODR  = 4'd1;
	localparam logic [3:0] S_WRITE = 4'd2;
	localparam logic [3:0] S_MODS  = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_DIVT  = 4'd5;
	localparam logic [3:0] S_DIVL  = 4'd6;
	localparam logic [3:0] S_RUN   = 4'd7;
	localparam logic [3:0] S_DRAIN = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;
	localparam logic [3:0] S_ADV   = 4'd10;

	// configuration registers
	logic [sc2d_pkg::IMAGE_W-1:0]  image_q;
	logic [sc2d_pkg::KERNEL_W-1:0] kernel_q;
	logic [sc2d_pkg::STRIDE_W-1:0] stride_q;
	logic [MW-1:0] eff_m;
	logic [KW-1:0] eff_k;

	// frame position and stride phases
	logic [WAW-1:0]                widx_q;
	logic [PW-1:0]                 pixel_row_q;
	logic [PW-1:0]                 pixel_col_q;
	logic [sc2d_pkg::STRIDE_W-1:0] row_phase_q;
	logic [sc2d_pkg::STRIDE_W-1:0] col_phase_q;

	// per-item working registers
	logic [3:0]                    state_q;
	logic [VALUE_BITS-1:0]         v_q;
	logic [SLW-1:0]                slot_q;
	logic [sc2d_pkg::STATUS_W-1:0] st_q;
	logic [PW-1:0]                 top_q;
	logic [PW-1:0]                 left_q;
	logic [KW-1:0]                 y_q;
	logic [SW-1:0]                 acc_q;
	logic [sc2d_pkg::POS_OUT_W-1:0] orow_q;
	logic [sc2d_pkg::POS_OUT_W-1:0] ocol_q;
	logic                          rlast_q;

	// divider interface
	logic          div_start_q;
	logic          div_go;
	logic [MW-1:0] div_n_q;
	logic [DW-1:0] div_d_q;
	logic          div_done;
	logic [MW-1:0] div_q;
	logic [DW-1:0] div_rem;

	logic          accept;
	logic          ww_en;
	logic          lw_en;
	logic [LAW-1:0] lw_addr;
	logic [WAW:0]  widx_inc;
	logic          win_ok;
	logic          out_free;
	logic [SLW:0]  slot_inc;

	// chain wiring, position i feeds cell i
	sc2d_pkg::flag_t tok   [MAX_KERNEL+1];
	sc2d_pkg::flag_t sflag [MAX_KERNEL+1];
	logic [SLW-1:0]  slot_c [MAX_KERNEL+1];
	logic [PW-1:0]   col_c  [MAX_KERNEL+1];
	logic [WAW-1:0]  wa_c   [MAX_KERNEL+1];
	logic [SW-1:0]   psum_c [MAX_KERNEL+1];

	// clamp out-of-range register values to the supported span
	always_comb begin
		if (image_q == '0) begin
			eff_m = MW'(1);
		end else if (32'(image_q) > MAX_IMAGE) begin
			eff_m = MW'(MAX_IMAGE);
		end else begin
			eff_m = MW'(image_q);
		end
		if (kernel_q == '0) begin
			eff_k = KW'(1);
		end else if (32'(kernel_q) > MAX_KERNEL) begin
			eff_k = KW'(MAX_KERNEL);
		end else begin
			eff_k = KW'(kernel_q);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ww_en    = accept && (opcode == sc2d_pkg::OP_WEIGHT);
	assign widx_inc = {1'b0, widx_q} + 1'b1;
	assign out_free = !out_valid || out_ready;

	// pixel lands in line slot (row mod k) at its column
	assign lw_en   = (state_q == S_WRITE);
	assign lw_addr = LAW'(slot_q) * LAW'(MAX_IMAGE) + LAW'(pixel_col_q);

	// pixel closes a window on the stride grid
	assign win_ok = (32'(pixel_row_q) + 1 >= 32'(eff_k)) && (32'(pixel_col_q) + 1 >= 32'(eff_k))
		&& (row_phase_q == '0) && (col_phase_q == '0)
		&& (32'(pixel_row_q) < 32'(eff_m)) && (32'(pixel_col_q) < 32'(eff_m));

	// first window row sits in slot (row+1) mod k, one past the slot just written
	assign slot_inc = {1'b0, slot_q} + 1'b1;

	// kick the divider: row mod k, then (m-k) mod stride, then top and left over stride
	always_comb begin
		case (state_q)
			S_IDLE:  div_go = accept && (opcode == sc2d_pkg::OP_PIXEL);
			S_WRITE: div_go = (32'(eff_k) <= 32'(eff_m)) && (stride_q != '0);
			S_CHK:   div_go = (st_q == sc2d_pkg::ST_OK) && win_ok;
			S_DIVT:  div_go = div_done;
			default: div_go = 1'b0;
		endcase
	end

	// the sequencer feeds column tokens into cell 0
	assign tok[0].valid = (state_q == S_RUN);
	assign tok[0].last  = (32'(y_q) + 1 == 32'(eff_k));
	assign slot_c[0]    = (32'(slot_inc) >= 32'(eff_k)) ? '0 : slot_inc[SLW-1:0];
	assign col_c[0]     = left_q + PW'(y_q);
	assign wa_c[0]      = WAW'(y_q);
	assign psum_c[0]    = '0;
	assign sflag[0]     = '0;

	for (genvar i = 0; i < MAX_KERNEL; i++) begin : g_cell
		sc2d_cell #(
			.IDX(i), .MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL), .VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .k(eff_k),
			.lw_en(lw_en), .lw_addr(lw_addr), .lw_data(v_q),
			.ww_en(ww_en), .ww_addr(widx_q), .ww_data(value),
			.tok_in(tok[i]), .slot_in(slot_c[i]), .col_in(col_c[i]), .wa_in(wa_c[i]),
			.tok_out(tok[i+1]), .slot_out(slot_c[i+1]), .col_out(col_c[i+1]),
			.wa_out(wa_c[i+1]),
			.psum_in(psum_c[i]), .psum_out(psum_c[i+1]), .sflag_out(sflag[i+1])
		);
	end

	sc2d_div #(.NW(MW), .DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .n(div_n_q), .d(div_d_q),
		.done(div_done), .q(div_q), .rem(div_rem)
	);

	// configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_q  <= sc2d_pkg::IMAGE_RST;
			kernel_q <= sc2d_pkg::KERNEL_RST;
			stride_q <= sc2d_pkg::STRIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sc2d_pkg::REG_IMAGE:  image_q  <= cfg_data[sc2d_pkg::IMAGE_W-1:0];
				sc2d_pkg::REG_KERNEL: kernel_q <= cfg_data[sc2d_pkg::KERNEL_W-1:0];
				sc2d_pkg::REG_STRIDE: stride_q <= cfg_data[sc2d_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, position tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			widx_q      <= '0;
			pixel_row_q <= '0;
			pixel_col_q <= '0;
			row_phase_q <= '0;
			col_phase_q <= '0;
			div_start_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			div_start_q <= div_go;
			// load the output register from emit, drop it once taken
			if (state_q == S_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (ww_en) begin
						// advance the weight slot, wrapping after k*k weights
						widx_q <= (32'(widx_inc) >= 32'(eff_k) * 32'(eff_k))
							? '0 : widx_inc[WAW-1:0];
					end else if (accept) begin
						state_q <= S_MODR;
					end
				end
				S_MODR: begin
					if (div_done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (32'(eff_k) > 32'(eff_m)) begin
						state_q <= S_CHK;
					end else if (stride_q == '0) begin
						state_q <= S_CHK;
					end else begin
						state_q <= S_MODS;
					end
				end
				S_MODS: begin
					if (div_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (st_q != sc2d_pkg::ST_OK) begin
						state_q <= (pixel_row_q == '0 && pixel_col_q == '0) ? S_EMIT : S_ADV;
					end else if (win_ok) begin
						state_q <= S_DIVT;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_DIVT: begin
					if (div_done) begin
						state_q <= S_DIVL;
					end
				end
				S_DIVL: begin
					if (div_done) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (tok[0].last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (sflag[MAX_KERNEL].valid && sflag[MAX_KERNEL].last) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					// advance column and row with their stride phases
					if (32'(pixel_col_q) + 1 >= 32'(eff_m)) begin
						pixel_col_q <= '0;
						col_phase_q <= '0;
						if (32'(pixel_row_q) + 1 >= 32'(eff_m)) begin
							pixel_row_q <= '0;
							row_phase_q <= '0;
						end else begin
							pixel_row_q <= pixel_row_q + 1'b1;
							if (32'(pixel_row_q) + 1 >= 32'(eff_k) && stride_q != '0) begin
								row_phase_q <= (32'(row_phase_q) + 1 >= 32'(stride_q))
									? '0 : row_phase_q + 1'b1;
							end
						end
					end else begin
						pixel_col_q <= pixel_col_q + 1'b1;
						if (32'(pixel_col_q) + 1 >= 32'(eff_k) && stride_q != '0) begin
							col_phase_q <= (32'(col_phase_q) + 1 >= 32'(stride_q))
								? '0 : col_phase_q + 1'b1;
						end
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers of the working item
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				v_q     <= value;
				div_n_q <= MW'(pixel_row_q);
				div_d_q <= DW'(eff_k);
			end
			S_MODR: begin
				slot_q <= SLW'(div_rem);
			end
			S_WRITE: begin
				div_n_q <= eff_m - MW'(eff_k);
				div_d_q <= stride_q;
				if (32'(eff_k) > 32'(eff_m)) begin
					st_q <= sc2d_pkg::ST_KERNEL;
				end else if (stride_q == '0) begin
					st_q <= sc2d_pkg::ST_STRIDE;
				end else begin
					st_q <= sc2d_pkg::ST_OK;
				end
			end
			S_MODS: begin
				if (div_done) begin
					st_q <= (div_rem != '0) ? sc2d_pkg::ST_STRIDE : sc2d_pkg::ST_OK;
				end
			end
			S_CHK: begin
				top_q   <= pixel_row_q + 1'b1 - PW'(eff_k);
				left_q  <= pixel_col_q + 1'b1 - PW'(eff_k);
				div_n_q <= MW'(pixel_row_q + 1'b1 - PW'(eff_k));
				div_d_q <= stride_q;
				acc_q   <= '0;
				orow_q  <= '0;
				ocol_q  <= '0;
				y_q     <= '0;
				rlast_q <= (st_q != sc2d_pkg::ST_OK)
					|| ((32'(pixel_row_q) + 1 == 32'(eff_m))
					&& (32'(pixel_col_q) + 1 == 32'(eff_m)));
			end
			S_DIVT: begin
				if (div_done) begin
					orow_q  <= sc2d_pkg::POS_OUT_W'(div_q);
					div_n_q <= MW'(left_q);
				end
			end
			S_DIVL: begin
				if (div_done) begin
					ocol_q <= sc2d_pkg::POS_OUT_W'(div_q);
				end
			end
			S_RUN: begin
				y_q <= y_q + 1'b1;
			end
			S_DRAIN: begin
				// fold each column sum leaving the chain into the window sum
				if (sflag[MAX_KERNEL].valid) begin
					acc_q <= acc_q + psum_c[MAX_KERNEL];
				end
			end
			S_EMIT: begin
				if (out_free) begin
					sum     <= acc_q;
					out_row <= orow_q;
					out_col <= ocol_q;
					last    <= rlast_q;
					status  <= st_q;
				end
			end
			default: ;
		endcase
	end

	// column sums leave the chain only while the sequencer waits for them
	a_drain_only: assert property (@(posedge clk) disable iff (!arst_n)
		sflag[MAX_KERNEL].valid |-> (state_q == S_DRAIN))
		else $error("column sum left the chain outside drain");

	// divider finishes only in a state that waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_MODR || state_q == S_MODS
			|| state_q == S_DIVT || state_q == S_DIVL))
		else $error("divider result with no consumer");

	// a result released from the emit state shows up on the port
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> out_valid)
		else $error("emitted result missing at the output");

	// the line slot stays below the kernel size whenever a pixel is written
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> (32'(slot_q) < 32'(eff_k)))
		else $error("line slot out of range");

endmodule
`default_nettype wire
